FILE: src/tret_pkg.sv
// Shared types and constants for the touch report event tracker.
package tret_pkg;

  // Screen coordinate and size width
  localparam int unsigned DimW = 12;
  // Panel range and scaling operand width
  localparam int unsigned RangeW = 16;
  // Raw point width: 16-bit panel value times 12-bit screen size
  localparam int unsigned RawW = RangeW + DimW;
  // One quotient bit per divider step
  localparam int unsigned DivSteps = RawW;
  localparam int unsigned DivCntW = $clog2(DivSteps);
  localparam int unsigned CfgIdxW = 3;

  // Status byte fields
  localparam logic [7:0] StReadyBit  = 8'h80;
  localparam logic [7:0] StCountMask = 8'h0F;
  localparam logic [3:0] MaxCountK0  = 4'd2;
  localparam logic [3:0] MaxCountK1  = 4'd5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PANEL_KIND    = 3'd0,
    CFG_SCREEN_WIDTH  = 3'd1,
    CFG_SCREEN_HEIGHT = 3'd2,
    CFG_X_RANGE       = 3'd3,
    CFG_Y_RANGE       = 3'd4,
    CFG_SWAP_XY       = 3'd5,
    CFG_MIRROR_X      = 3'd6,
    CFG_MIRROR_Y      = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EV_DOWN = 2'd0,
    EV_MOVE = 2'd1,
    EV_UP   = 2'd2
  } event_kind_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture the accepted request
    logic decode;    // decode the report, start scaling if needed
    logic take_div;  // load scaled raw point from the dividers
    logic place;     // map point to screen, update tracking state
    logic emit;      // move result into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_div;  // decoded report needs scaling
    logic div_busy;  // either divider still iterating
    logic out_free;  // output register can take a result
  } status_t;

endpackage

FILE: src/tret_div.sv
// Restoring divider, one quotient bit per cycle.
module tret_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [tret_pkg::RawW-1:0]      dividend_i,
  input  logic [tret_pkg::RangeW-1:0]    divisor_i,
  output logic                           busy_o,
  output logic [tret_pkg::RawW-1:0]      quotient_o
);

  logic                               busy_q, busy_d;
  logic [tret_pkg::DivCntW-1:0]       cnt_q, cnt_d;
  logic [tret_pkg::RawW-1:0]          quo_q, quo_d;
  logic [tret_pkg::RangeW-1:0]        rem_q, rem_d;
  logic [tret_pkg::RangeW-1:0]        dvs_q, dvs_d;
  logic [tret_pkg::RangeW:0]          rem_sh;
  logic [tret_pkg::RangeW:0]          rem_sub;

  // Shift in next dividend bit and trial-subtract
  assign rem_sh  = {rem_q, quo_q[tret_pkg::RawW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = tret_pkg::DivCntW'(tret_pkg::DivSteps - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sub[tret_pkg::RangeW-1:0];
        quo_d = {quo_q[tret_pkg::RawW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[tret_pkg::RangeW-1:0];
        quo_d = {quo_q[tret_pkg::RawW-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

FILE: src/tret_datapath.sv
// Datapath: config registers, report decode, scaling, placement and output register.
module tret_datapath #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [tret_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tret_pkg::RangeW-1:0]     cfg_wdata_i,
  // request payload
  input  logic                            status_ok_i,
  input  logic [7:0]                      status_byte_i,
  input  logic                            points_ok_i,
  input  logic [7:0]                      coord_byte1_i,
  input  logic [7:0]                      coord_byte2_i,
  input  logic [7:0]                      coord_byte3_i,
  input  logic [7:0]                      coord_byte4_i,
  // result
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic                            has_event_o,
  output logic [1:0]                      event_kind_o,
  output logic [tret_pkg::DimW-1:0]       point_x_o,
  output logic [tret_pkg::DimW-1:0]       point_y_o,
  output logic                            clear_status_o,
  // control
  input  tret_pkg::cmd_t                  cmd_i,
  output tret_pkg::status_t               status_o
);

  localparam int unsigned DimW   = tret_pkg::DimW;
  localparam int unsigned RangeW = tret_pkg::RangeW;
  localparam int unsigned RawW   = tret_pkg::RawW;
  // High-nibble mask for the packed layout
  localparam logic [7:0] HiMask = 8'((1 << (COORD_BITS - 8)) - 1);

  // Configuration registers
  logic              kind_q, swap_q, mir_x_q, mir_y_q;
  logic [DimW-1:0]   width_q, height_q;
  logic [RangeW-1:0] xrng_q, yrng_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q   <= 1'b0;
      width_q  <= DimW'(320);
      height_q <= DimW'(480);
      xrng_q   <= RangeW'(320);
      yrng_q   <= RangeW'(480);
      swap_q   <= 1'b0;
      mir_x_q  <= 1'b0;
      mir_y_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (tret_pkg::cfg_idx_e'(cfg_idx_i))
        tret_pkg::CFG_PANEL_KIND:    kind_q   <= cfg_wdata_i[0];
        tret_pkg::CFG_SCREEN_WIDTH:  width_q  <= cfg_wdata_i[DimW-1:0];
        tret_pkg::CFG_SCREEN_HEIGHT: height_q <= cfg_wdata_i[DimW-1:0];
        tret_pkg::CFG_X_RANGE:       xrng_q   <= cfg_wdata_i;
        tret_pkg::CFG_Y_RANGE:       yrng_q   <= cfg_wdata_i;
        tret_pkg::CFG_SWAP_XY:       swap_q   <= cfg_wdata_i[0];
        tret_pkg::CFG_MIRROR_X:      mir_x_q  <= cfg_wdata_i[0];
        tret_pkg::CFG_MIRROR_Y:      mir_y_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Zero screen size acts as one
  logic [DimW-1:0] w_eff, h_eff;
  assign w_eff = (width_q  == '0) ? DimW'(1) : width_q;
  assign h_eff = (height_q == '0) ? DimW'(1) : height_q;

  // Captured request
  logic       st_ok_q, pt_ok_q;
  logic [7:0] st_q, b1_q, b2_q, b3_q, b4_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      st_ok_q <= status_ok_i;
      st_q    <= status_byte_i;
      pt_ok_q <= points_ok_i;
      b1_q    <= coord_byte1_i;
      b2_q    <= coord_byte2_i;
      b3_q    <= coord_byte3_i;
      b4_q    <= coord_byte4_i;
    end
  end

  // Report decode
  logic [3:0]        cnt;
  logic              st_ready;
  logic              k0_touch, k1_touch;
  logic [RangeW-1:0] vx, vy;
  logic [RawW-1:0]   k0_raw_x, k0_raw_y;

  assign cnt      = 4'(st_q & tret_pkg::StCountMask);
  assign st_ready = |(st_q & tret_pkg::StReadyBit);
  assign k0_touch = st_ok_q && (cnt != '0) && (cnt <= tret_pkg::MaxCountK0);
  assign k1_touch = (cnt != '0) && (cnt <= tret_pkg::MaxCountK1) && pt_ok_q;
  assign vx       = {b2_q, b1_q};
  assign vy       = {b4_q, b3_q};
  assign k0_raw_x = RawW'({b1_q & HiMask, b2_q});
  assign k0_raw_y = RawW'({b3_q & HiMask, b4_q});

  assign status_o.need_div = kind_q && st_ok_q && st_ready && k1_touch;

  // Tracking state
  logic            touch_q, touch_d, down_q, down_d, clr_q, clr_d;
  logic [RawW-1:0] raw_x_q, raw_x_d, raw_y_q, raw_y_d;
  logic [DimW-1:0] last_x_q, last_x_d, last_y_q, last_y_d;

  // Scaling dividers
  logic [RawW-1:0] prod_x, prod_y, quo_x, quo_y;
  logic            busy_x, busy_y, div_start;

  assign prod_x    = RawW'(vx) * RawW'(w_eff);
  assign prod_y    = RawW'(vy) * RawW'(h_eff);
  assign div_start = cmd_i.decode && status_o.need_div;

  tret_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_x),
    .divisor_i  (xrng_q),
    .busy_o     (busy_x),
    .quotient_o (quo_x)
  );

  tret_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_y),
    .divisor_i  (yrng_q),
    .busy_o     (busy_y),
    .quotient_o (quo_y)
  );

  assign status_o.div_busy = busy_x || busy_y;

  // Mirror and clamp one axis to the screen
  function automatic logic [DimW-1:0] place_axis(input logic [RawW-1:0] v,
                                                 input logic mir,
                                                 input logic [DimW-1:0] size);
    logic [DimW-1:0] top;
    top = size - 1'b1;
    if (mir) begin
      if (v > RawW'(top)) place_axis = '0;
      else                place_axis = top - v[DimW-1:0];
    end else begin
      if (v >= RawW'(size)) place_axis = top;
      else                  place_axis = v[DimW-1:0];
    end
  endfunction

  logic [RawW-1:0] sx, sy;
  assign sx = swap_q ? raw_y_q : raw_x_q;
  assign sy = swap_q ? raw_x_q : raw_y_q;

  // Pending result
  logic            res_has_q, res_has_d;
  logic [1:0]      res_ev_q, res_ev_d;
  logic [DimW-1:0] res_x_q, res_x_d, res_y_q, res_y_d;

  always_comb begin
    touch_d   = touch_q;
    down_d    = down_q;
    clr_d     = clr_q;
    raw_x_d   = raw_x_q;
    raw_y_d   = raw_y_q;
    last_x_d  = last_x_q;
    last_y_d  = last_y_q;
    res_has_d = res_has_q;
    res_ev_d  = res_ev_q;
    res_x_d   = res_x_q;
    res_y_d   = res_y_q;

    if (cmd_i.decode) begin
      clr_d = 1'b0;
      if (!kind_q) begin
        down_d = k0_touch;
        if (k0_touch) begin
          raw_x_d = k0_raw_x;
          raw_y_d = k0_raw_y;
        end
      end else if (!st_ok_q) begin
        down_d = 1'b0;
      end else if (st_ready) begin
        clr_d  = 1'b1;
        down_d = k1_touch;
      end else begin
        // No new report: state holds
        down_d = touch_q;
      end
    end

    // Zero range passes the coordinate unscaled
    if (cmd_i.take_div) begin
      raw_x_d = (xrng_q == '0) ? RawW'(vx) : quo_x;
      raw_y_d = (yrng_q == '0) ? RawW'(vy) : quo_y;
    end

    if (cmd_i.place) begin
      res_has_d = 1'b0;
      res_ev_d  = tret_pkg::EV_DOWN;
      res_x_d   = '0;
      res_y_d   = '0;
      if (down_q) begin
        last_x_d  = place_axis(sx, mir_x_q, w_eff);
        last_y_d  = place_axis(sy, mir_y_q, h_eff);
        res_has_d = 1'b1;
        res_ev_d  = touch_q ? tret_pkg::EV_MOVE : tret_pkg::EV_DOWN;
        res_x_d   = last_x_d;
        res_y_d   = last_y_d;
      end else if (touch_q) begin
        res_has_d = 1'b1;
        res_ev_d  = tret_pkg::EV_UP;
        res_x_d   = last_x_q;
        res_y_d   = last_y_q;
      end
      touch_d = down_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touch_q  <= 1'b0;
      raw_x_q  <= '0;
      raw_y_q  <= '0;
      last_x_q <= '0;
      last_y_q <= '0;
    end else begin
      touch_q  <= touch_d;
      raw_x_q  <= raw_x_d;
      raw_y_q  <= raw_y_d;
      last_x_q <= last_x_d;
      last_y_q <= last_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    down_q    <= down_d;
    clr_q     <= clr_d;
    res_has_q <= res_has_d;
    res_ev_q  <= res_ev_d;
    res_x_q   <= res_x_d;
    res_y_q   <= res_y_d;
  end

  // Output register
  logic            out_valid_q, out_valid_d;
  logic            out_has_q, out_clr_q;
  logic [1:0]      out_ev_q;
  logic [DimW-1:0] out_x_q, out_y_q;

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit)       out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_has_q <= res_has_q;
      out_ev_q  <= res_ev_q;
      out_x_q   <= res_x_q;
      out_y_q   <= res_y_q;
      out_clr_q <= clr_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign has_event_o    = out_has_q;
  assign event_kind_o   = out_ev_q;
  assign point_x_o      = out_x_q;
  assign point_y_o      = out_y_q;
  assign clear_status_o = out_clr_q;

endmodule

FILE: src/tret_ctrl.sv
// Controller state machine sequencing one report through the datapath.
module tret_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tret_pkg::status_t status_i,
  output tret_pkg::cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_DIV    = 5'b00100,
    S_PLACE  = 5'b01000,
    S_EMIT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d      = status_i.need_div ? S_DIV : S_PLACE;
      end
      S_DIV: begin
        if (!status_i.div_busy) begin
          cmd_o.take_div = 1'b1;
          state_d        = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        // wait for the output register to free up
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

FILE: src/touch_report_event_tracker_unit.sv
// Top level of the touch report event tracker.
//
// Usage: each request on the input channel (valid/ready) is one touch-panel
// report read. Every request yields exactly one result on the output channel
// (valid/ready): an optional DOWN/MOVE/UP event with its screen point and a
// status-clear flag. Configuration is written through cfg_we_i/cfg_idx_i/
// cfg_wdata_i; the user must write it only while the block is idle, which
// the block itself does not enforce. Writes take effect at once.
// Scaling: a report that needs scaling (ready-flagged layout with a valid
// touch) waits for the two 28-step iterative dividers that run in parallel
// for x and y; other reports skip them. One request is in flight at a time,
// so the input accepts again in the cycle after the result enters the output
// register. Stall: the result waits in the output register; a new request
// may be accepted and processed meanwhile, and it then waits until the
// output register is taken before it is emitted.
// Reset: clears the touch state, the last point, the held raw point and the
// output valid, and loads the default screen and range configuration.
module touch_report_event_tracker_unit #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tret_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tret_pkg::RangeW-1:0]    cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           status_ok_i,
  input  logic [7:0]                     status_byte_i,
  input  logic                           points_ok_i,
  input  logic [7:0]                     coord_byte1_i,
  input  logic [7:0]                     coord_byte2_i,
  input  logic [7:0]                     coord_byte3_i,
  input  logic [7:0]                     coord_byte4_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           has_event_o,
  output logic [1:0]                     event_kind_o,
  output logic [tret_pkg::DimW-1:0]      point_x_o,
  output logic [tret_pkg::DimW-1:0]      point_y_o,
  output logic                           clear_status_o
);

  tret_pkg::cmd_t    cmd;
  tret_pkg::status_t status;

  tret_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tret_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .status_ok_i    (status_ok_i),
    .status_byte_i  (status_byte_i),
    .points_ok_i    (points_ok_i),
    .coord_byte1_i  (coord_byte1_i),
    .coord_byte2_i  (coord_byte2_i),
    .coord_byte3_i  (coord_byte3_i),
    .coord_byte4_i  (coord_byte4_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .has_event_o    (has_event_o),
    .event_kind_o   (event_kind_o),
    .point_x_o      (point_x_o),
    .point_y_o      (point_y_o),
    .clear_status_o (clear_status_o),
    .cmd_i          (cmd),
    .status_o       (status)
  );

endmodule

FILE: src/tret_chk.sv
// Port-level checker for the touch report event tracker, bound to the top level.
module tret_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic                      has_event_o,
  input logic [1:0]                event_kind_o,
  input logic [tret_pkg::DimW-1:0] point_x_o,
  input logic [tret_pkg::DimW-1:0] point_y_o,
  input logic                      clear_status_o
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(has_event_o) &&
      $stable(event_kind_o) && $stable(point_x_o) && $stable(point_y_o) &&
      $stable(clear_status_o))
    else $error("stalled result changed");

  // No event means a zeroed kind and point
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_event_o |->
      event_kind_o == tret_pkg::EV_DOWN && point_x_o == '0 && point_y_o == '0)
    else $error("empty result carries event data");

  // Only the three defined event kinds appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_event_o |->
      event_kind_o == tret_pkg::EV_DOWN || event_kind_o == tret_pkg::EV_MOVE ||
      event_kind_o == tret_pkg::EV_UP)
    else $error("undefined event kind");

  // One report in flight: no request taken right after another
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in flight");

endmodule

bind touch_report_event_tracker_unit tret_chk u_tret_chk (.*);

FILE: bench/touch_report_event_tracker_unit_tb.sv
// Self-checking bench for the touch report event tracker: directed and random reports.
`timescale 1ns / 1ps

module touch_report_event_tracker_unit_tb;

  localparam int unsigned CoordBits  = 12;
  localparam logic [7:0]  HiMask     = 8'((1 << (CoordBits - 8)) - 1);
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned SettleCyc  = 8;
  localparam int unsigned TailCyc    = 40;
  localparam int unsigned HoldOffCyc = 300;
  localparam int unsigned RandPhases = 10;
  localparam int unsigned PhaseLen   = 200;
  localparam logic        PanelNibble = 1'b0;
  localparam logic        PanelScaled = 1'b1;

  // One report read as presented on the request channel
  typedef struct packed {
    logic       st_ok;
    logic [7:0] st;
    logic       pt_ok;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
  } report_t;

  typedef struct packed {
    logic                           has;
    tret_pkg::event_kind_e          kind;
    logic [tret_pkg::DimW-1:0]      x;
    logic [tret_pkg::DimW-1:0]      y;
    logic                           clr;
  } touch_event_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [tret_pkg::CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [tret_pkg::RangeW-1:0]    cfg_wdata_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  logic                           status_ok_i = 1'b0;
  logic [7:0]                     status_byte_i = '0;
  logic                           points_ok_i = 1'b0;
  logic [7:0]                     coord_byte1_i = '0;
  logic [7:0]                     coord_byte2_i = '0;
  logic [7:0]                     coord_byte3_i = '0;
  logic [7:0]                     coord_byte4_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic                           has_event_o;
  logic [1:0]                     event_kind_o;
  logic [tret_pkg::DimW-1:0]      point_x_o;
  logic [tret_pkg::DimW-1:0]      point_y_o;
  logic                           clear_status_o;

  // Mirror of the block's configuration and tracking state
  logic                           kind_q;
  logic [tret_pkg::DimW-1:0]      width_q, height_q;
  logic [tret_pkg::RangeW-1:0]    xrange_q, yrange_q;
  logic                           swap_q, mirx_q, miry_q;
  logic                           touching_q;
  logic [tret_pkg::DimW-1:0]      last_x_q, last_y_q;
  longint unsigned                raw_x_q, raw_y_q;

  touch_event_t      pending_events[$];
  int unsigned       mismatch_count = 0;
  int unsigned       cycle_count = 0;
  int unsigned       rx_hold = 0;
  logic              tx_quiet = 1'b0;
  logic              rx_quiet = 1'b0;
  logic              stroke_on = 1'b0;

  touch_report_event_tracker_unit #(
    .COORD_BITS(CoordBits)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .status_ok_i   (status_ok_i),
    .status_byte_i (status_byte_i),
    .points_ok_i   (points_ok_i),
    .coord_byte1_i (coord_byte1_i),
    .coord_byte2_i (coord_byte2_i),
    .coord_byte3_i (coord_byte3_i),
    .coord_byte4_i (coord_byte4_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .has_event_o   (has_event_o),
    .event_kind_o  (event_kind_o),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .clear_status_o(clear_status_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Run guard
  initial begin : watchdog
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("touch_report_event_tracker_unit_tb: errors");
    $finish;
  end

  // Idle length: mostly short, now and then long
  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Panel value times screen size over panel range; zero range passes through
  function automatic longint unsigned stretch(longint unsigned v, int unsigned size,
                                              logic [tret_pkg::RangeW-1:0] span);
    if (span == 0) return v;
    return v * size / span;
  endfunction

  // Optional mirror, then clamp onto the screen
  function automatic logic [tret_pkg::DimW-1:0] fit_axis(longint unsigned v, logic flip,
                                                         int unsigned size);
    longint s;
    s = longint'(v);
    if (flip) s = longint'(size) - 1 - s;
    if (s < 0) return '0;
    if (s >= longint'(size)) return tret_pkg::DimW'(size - 1);
    return tret_pkg::DimW'(s);
  endfunction

  // Decode one report and advance the tracking state
  function automatic touch_event_t decode_report(report_t r);
    touch_event_t    ev;
    int unsigned     w, h;
    logic [3:0]      count;
    logic            press;
    longint unsigned sx, sy;
    w = (width_q == 0) ? 1 : width_q;
    h = (height_q == 0) ? 1 : height_q;
    count = r.st[3:0] & tret_pkg::StCountMask[3:0];
    ev = '0;
    press = touching_q;
    if (kind_q == PanelNibble) begin
      press = 1'b0;
      if (r.st_ok && count >= 1 && count <= tret_pkg::MaxCountK0) begin
        raw_x_q = {r.b1 & HiMask, r.b2};
        raw_y_q = {r.b3 & HiMask, r.b4};
        press = 1'b1;
      end
    end else if (!r.st_ok) begin
      press = 1'b0;
    end else if ((r.st & tret_pkg::StReadyBit) != 0) begin
      ev.clr = 1'b1;
      press = 1'b0;
      if (count >= 1 && count <= tret_pkg::MaxCountK1 && r.pt_ok) begin
        raw_x_q = stretch({r.b2, r.b1}, w, xrange_q);
        raw_y_q = stretch({r.b4, r.b3}, h, yrange_q);
        press = 1'b1;
      end
    end
    // without a ready bit the held point and touch state carry over
    if (press) begin
      sx = swap_q ? raw_y_q : raw_x_q;
      sy = swap_q ? raw_x_q : raw_y_q;
      last_x_q = fit_axis(sx, mirx_q, w);
      last_y_q = fit_axis(sy, miry_q, h);
      ev.has = 1'b1;
      ev.kind = touching_q ? tret_pkg::EV_MOVE : tret_pkg::EV_DOWN;
      ev.x = last_x_q;
      ev.y = last_y_q;
    end else if (touching_q) begin
      ev.has = 1'b1;
      ev.kind = tret_pkg::EV_UP;
      ev.x = last_x_q;
      ev.y = last_y_q;
    end
    touching_q = press;
    return ev;
  endfunction

  function automatic report_t mk(logic st_ok, logic [7:0] st, logic pt_ok, logic [7:0] b1,
                                 logic [7:0] b2, logic [7:0] b3, logic [7:0] b4);
    return '{st_ok, st, pt_ok, b1, b2, b3, b4};
  endfunction

  // Random report: mostly touch strokes, the rest releases and malformed reads
  function automatic report_t random_report();
    report_t                      r;
    int unsigned                  p;
    logic [tret_pkg::RangeW-1:0]  v;
    r = mk(1'b1, 8'($urandom_range(255)), 1'b1, 8'($urandom_range(255)),
           8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    p = $urandom_range(99);
    stroke_on = stroke_on ? (p < 80) : (p < 45);
    if (kind_q == PanelNibble) begin
      r.pt_ok = 1'($urandom_range(1));
      if (stroke_on) begin
        r.st[3:0] = 4'($urandom_range(1, tret_pkg::MaxCountK0));
      end else begin
        case ($urandom_range(2))
          0: r.st_ok = 1'b0;
          1: r.st[3:0] = 4'd0;
          default: r.st[3:0] = 4'($urandom_range(tret_pkg::MaxCountK0 + 1, 15));
        endcase
      end
    end else if (stroke_on) begin
      r.st[7] = 1'b1;
      r.st[3:0] = 4'($urandom_range(1, tret_pkg::MaxCountK1));
      // draw half of the points from inside the panel range so clamping is not the norm
      if ($urandom_range(1)) begin
        v = tret_pkg::RangeW'($urandom_range(0, xrange_q));
        {r.b2, r.b1} = v;
        v = tret_pkg::RangeW'($urandom_range(0, yrange_q));
        {r.b4, r.b3} = v;
      end
      // an unready poll in the middle of a stroke
      if (p % 10 == 0) r.st[7] = 1'b0;
    end else begin
      case ($urandom_range(3))
        0: r.st_ok = 1'b0;
        1: begin
          r.st[7] = 1'b1;
          r.st[3:0] = $urandom_range(1) ? 4'd0 :
                      4'($urandom_range(tret_pkg::MaxCountK1 + 1, 15));
        end
        2: begin
          r.st[7] = 1'b1;
          r.st[3:0] = 4'($urandom_range(1, tret_pkg::MaxCountK1));
          r.pt_ok = 1'b0;
        end
        default: r.st[7] = 1'b0;
      endcase
    end
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Offer one request, record its expected event, then idle for a random gap that may be zero
  task automatic send_report(report_t r);
    int unsigned gap;
    status_ok_i = r.st_ok;
    status_byte_i = r.st;
    points_ok_i = r.pt_ok;
    coord_byte1_i = r.b1;
    coord_byte2_i = r.b2;
    coord_byte3_i = r.b3;
    coord_byte4_i = r.b4;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_events.push_back(decode_report(r));
    @(negedge clk_i);
    gap = tx_quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Stop offering and wait for every outstanding event
  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_events.size() != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  task automatic write_reg(tret_pkg::cfg_idx_e idx, logic [tret_pkg::RangeW-1:0] v);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      tret_pkg::CFG_PANEL_KIND:    kind_q = v[0];
      tret_pkg::CFG_SCREEN_WIDTH:  width_q = v[tret_pkg::DimW-1:0];
      tret_pkg::CFG_SCREEN_HEIGHT: height_q = v[tret_pkg::DimW-1:0];
      tret_pkg::CFG_X_RANGE:       xrange_q = v;
      tret_pkg::CFG_Y_RANGE:       yrange_q = v;
      tret_pkg::CFG_SWAP_XY:       swap_q = v[0];
      tret_pkg::CFG_MIRROR_X:      mirx_q = v[0];
      tret_pkg::CFG_MIRROR_Y:      miry_q = v[0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic kind, logic [tret_pkg::DimW-1:0] w,
                               logic [tret_pkg::DimW-1:0] h,
                               logic [tret_pkg::RangeW-1:0] xr,
                               logic [tret_pkg::RangeW-1:0] yr,
                               logic sw, logic mx, logic my);
    write_reg(tret_pkg::CFG_PANEL_KIND, tret_pkg::RangeW'(kind));
    write_reg(tret_pkg::CFG_SCREEN_WIDTH, tret_pkg::RangeW'(w));
    write_reg(tret_pkg::CFG_SCREEN_HEIGHT, tret_pkg::RangeW'(h));
    write_reg(tret_pkg::CFG_X_RANGE, xr);
    write_reg(tret_pkg::CFG_Y_RANGE, yr);
    write_reg(tret_pkg::CFG_SWAP_XY, tret_pkg::RangeW'(sw));
    write_reg(tret_pkg::CFG_MIRROR_X, tret_pkg::RangeW'(mx));
    write_reg(tret_pkg::CFG_MIRROR_Y, tret_pkg::RangeW'(my));
  endtask

  // Receiver: random stalls, plus a long hold-off counted here on request
  initial begin : rx_drive
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        out_ready_i = 1'b0;
        rx_hold--;
      end else if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = 1'b1;
        stall_left = rx_quiet ? 0 : idle_len();
      end
    end
  end

  // Compare each delivered result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    touch_event_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_events.size() == 0) begin
        $error("result with no request outstanding");
        mismatch_count++;
      end else begin
        want = pending_events.pop_front();
        check_field("has_event", want.has, has_event_o);
        check_field("event_kind", want.kind, event_kind_o);
        check_field("point_x", want.x, point_x_o);
        check_field("point_y", want.y, point_y_o);
        check_field("clear_status", want.clr, clear_status_o);
      end
    end
  end

  // Nibble-packed layout at reset settings: counts, masking, clamping
  task automatic test_nibble_layout();
    send_report(mk(1'b1, 8'h01, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(mk(1'b1, 8'h02, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_report(mk(1'b1, 8'h03, 1'b0, 8'h01, 8'h00, 8'h01, 8'h00));
    send_report(mk(1'b1, 8'h00, 1'b0, 8'h00, 8'h10, 8'h00, 8'h10));
    send_report(mk(1'b0, 8'h01, 1'b1, 8'h00, 8'h10, 8'h00, 8'h10));
    send_report(mk(1'b1, 8'hF1, 1'b0, 8'hA1, 8'h23, 8'h50, 8'h45));
    send_report(mk(1'b0, 8'hFF, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    drain();
  endtask

  // Ready-flagged scaled layout: ready bit, count limits, failed point read
  task automatic test_scaled_layout();
    write_reg(tret_pkg::CFG_PANEL_KIND, tret_pkg::RangeW'(PanelScaled));
    write_reg(tret_pkg::CFG_X_RANGE, 16'd640);
    write_reg(tret_pkg::CFG_Y_RANGE, 16'd960);
    send_report(mk(1'b1, 8'h81, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(mk(1'b1, 8'h85, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_report(mk(1'b1, 8'h01, 1'b1, 8'h10, 8'h00, 8'h10, 8'h00));
    send_report(mk(1'b1, 8'h86, 1'b1, 8'h10, 8'h00, 8'h10, 8'h00));
    send_report(mk(1'b1, 8'h01, 1'b1, 8'h10, 8'h00, 8'h10, 8'h00));
    send_report(mk(1'b1, 8'h81, 1'b0, 8'h10, 8'h00, 8'h10, 8'h00));
    send_report(mk(1'b1, 8'h81, 1'b1, 8'h64, 8'h00, 8'hC8, 8'h00));
    send_report(mk(1'b0, 8'h81, 1'b1, 8'h64, 8'h00, 8'hC8, 8'h00));
    drain();
  endtask

  // Swap and both mirrors, including clamping below zero
  task automatic test_orientation();
    load_settings(PanelNibble, 12'd320, 12'd480, 16'd320, 16'd480, 1'b1, 1'b1, 1'b1);
    send_report(mk(1'b1, 8'h01, 1'b0, 8'h00, 8'h0A, 8'h01, 8'h90));
    send_report(mk(1'b1, 8'h01, 1'b0, 8'h0F, 8'hFF, 8'h00, 8'h00));
    send_report(mk(1'b1, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
    drain();
  endtask

  // Zero screen sizes act as one, zero ranges leave values unscaled
  task automatic test_zero_sizes();
    load_settings(PanelScaled, 12'd0, 12'd0, 16'd0, 16'd0, 1'b0, 1'b1, 1'b0);
    send_report(mk(1'b1, 8'h81, 1'b1, 8'h05, 8'h00, 8'h07, 8'h00));
    send_report(mk(1'b1, 8'h80, 1'b1, 8'h05, 8'h00, 8'h07, 8'h00));
    drain();
  endtask

  // A point held from the nibble layout is reused after switching layouts
  task automatic test_held_point_across_kind();
    load_settings(PanelNibble, 12'd320, 12'd480, 16'd320, 16'd480, 1'b0, 1'b0, 1'b0);
    send_report(mk(1'b1, 8'h01, 1'b0, 8'h00, 8'h32, 8'h00, 8'h3C));
    drain();
    write_reg(tret_pkg::CFG_PANEL_KIND, tret_pkg::RangeW'(PanelScaled));
    send_report(mk(1'b1, 8'h01, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_report(mk(1'b0, 8'h81, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00));
    drain();
  endtask

  // Receiver holds off while the sender keeps offering back to back
  task automatic test_output_backpressure();
    tx_quiet = 1'b1;
    rx_hold = HoldOffCyc;
    repeat (24) send_report(random_report());
    tx_quiet = 1'b0;
    drain();
  endtask

  // Random streams over a series of settings, extremes first
  task automatic test_random_streams();
    logic [tret_pkg::DimW-1:0]   w, h;
    logic [tret_pkg::RangeW-1:0] xr, yr;
    for (int unsigned ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        0: load_settings(PanelNibble, 12'd1, 12'd1, 16'd1, 16'd1, 1'b0, 1'b0, 1'b0);
        1: load_settings(PanelScaled, 12'd4095, 12'd4095, 16'hFFFF, 16'hFFFF,
                         1'b1, 1'b1, 1'b1);
        2: load_settings(PanelScaled, 12'd0, 12'd0, 16'd0, 16'd0, 1'b1, 1'b0, 1'b1);
        default: begin
          w = ($urandom_range(9) == 0) ? 12'd4095 :
              tret_pkg::DimW'($urandom_range(16, 1024));
          h = ($urandom_range(9) == 0) ? 12'd0 :
              tret_pkg::DimW'($urandom_range(16, 1024));
          xr = ($urandom_range(9) == 0) ? 16'd0 :
               tret_pkg::RangeW'($urandom_range(1, 4096));
          yr = ($urandom_range(9) == 0) ? 16'hFFFF :
               tret_pkg::RangeW'($urandom_range(1, 4096));
          load_settings(1'($urandom_range(1)), w, h, xr, yr, 1'($urandom_range(1)),
                        1'($urandom_range(1)), 1'($urandom_range(1)));
        end
      endcase
      tx_quiet = (ph == 3);
      rx_quiet = (ph == 3 || ph == 7);
      repeat (PhaseLen) send_report(random_report());
      drain();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    // predictor starts from the reset configuration
    kind_q = PanelNibble;
    width_q = 12'd320;
    height_q = 12'd480;
    xrange_q = 16'd320;
    yrange_q = 16'd480;
    swap_q = 1'b0;
    mirx_q = 1'b0;
    miry_q = 1'b0;
    touching_q = 1'b0;
    last_x_q = '0;
    last_y_q = '0;
    raw_x_q = 0;
    raw_y_q = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_nibble_layout();
    test_scaled_layout();
    test_orientation();
    test_zero_sizes();
    test_held_point_across_kind();
    test_output_backpressure();
    test_random_streams();
    drain();
    repeat (TailCyc) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("touch_report_event_tracker_unit_tb: clean");
    end else begin
      $display("touch_report_event_tracker_unit_tb: errors");
    end
    $finish;
  end

endmodule

FILE: touch_report_event_tracker_unit.f
src/tret_pkg.sv
src/tret_div.sv
src/tret_datapath.sv
src/tret_ctrl.sv
src/touch_report_event_tracker_unit.sv
src/tret_chk.sv
bench/touch_report_event_tracker_unit_tb.sv
